/* sv/glb_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// glb_pkg
// Shared types and constants of the greedy line breaker.
// ----------------------------------------------------------------------------
package glb_pkg;

  localparam int unsigned MaxTextLen = 65536;
  localparam int unsigned CntW = 17;
  localparam int unsigned MetW = 20;
  localparam int unsigned HgtW = 22;
  localparam int unsigned WidW = 24;
  localparam int unsigned AdvW = 20;
  localparam int unsigned ByteW = 16;

  localparam logic [1:0] ClsOrdinary = 2'd0;
  localparam logic [1:0] ClsNewline  = 2'd1;
  localparam logic [1:0] ClsBreak    = 2'd2;
  localparam logic [1:0] ClsUnknown  = 2'd3;

  localparam logic RegWrapMode  = 1'b0;
  localparam logic RegWrapWidth = 1'b1;

  typedef struct packed {
    logic [AdvW-1:0]  advance;
    logic [ByteW-1:0] byte_pos;
    logic [1:0]       char_class;
    logic [MetW-1:0]  glyph_ascent;
    logic [MetW-1:0]  glyph_descent;
    logic [MetW-1:0]  glyph_line_gap;
    logic             final_glyph;
    logic [CntW-1:0]  text_bytes;
  } glyph_t;

  typedef struct packed {
    logic [CntW-1:0] line_first_glyph;
    logic [CntW-1:0] line_glyphs;
    logic [CntW-1:0] line_first_byte;
    logic [CntW-1:0] line_bytes;
    logic [WidW-1:0] line_width;
    logic [MetW-1:0] line_ascent;
    logic [MetW-1:0] line_descent;
    logic [HgtW-1:0] line_height;
    logic [WidW-1:0] text_width;
    logic [WidW-1:0] text_height;
    logic            last_line;
  } line_t;

  typedef struct packed {
    logic [MetW-1:0] asc;
    logic [MetW-1:0] desc;
    logic [HgtW-1:0] hgt;
  } metrics_t;

  // Glyph after the front stage: sums and class decoded.
  typedef struct packed {
    glyph_t          g;
    metrics_t        m;
    logic            is_nl;
    logic            is_brk;
  } front_t;

  typedef struct packed {
    logic wrap_mode;
    logic [WidW-1:0] wrap_width;
  } cfg_t;

  function automatic metrics_t mmax(metrics_t a, metrics_t b);
    metrics_t r;
    r.asc  = (a.asc > b.asc) ? a.asc : b.asc;
    r.desc = (a.desc > b.desc) ? a.desc : b.desc;
    r.hgt  = (a.hgt > b.hgt) ? a.hgt : b.hgt;
    return r;
  endfunction

  function automatic logic [WidW-1:0] sat24(logic [WidW:0] v);
    return v[WidW] ? {WidW{1'b1}} : v[WidW-1:0];
  endfunction

endpackage
`default_nettype wire

/* sv/glb_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// glb_glyph_if / glb_line_if / glb_cfg_if
// Valid/ready channels of the line breaker.
// ----------------------------------------------------------------------------
interface glb_glyph_if;
  logic valid;
  logic ready;
  glb_pkg::glyph_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface glb_line_if;
  logic valid;
  logic ready;
  glb_pkg::line_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface glb_cfg_if;
  logic valid;
  logic ready;
  logic index;
  logic [31:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

/* sv/greedy_line_breaker_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// greedy_line_breaker_top
// Greedy line breaking over a glyph stream, emitting line records.
// ----------------------------------------------------------------------------
// Each glyph is written into the front queue, then its record is registered
// by the back stage.
// Throughput: one glyph per cycle while the output takes records; a glyph that
// yields two records holds the back stage until the second record drains.
// Reset: asynchronous active-low; clears registers, line state and queues.
module greedy_line_breaker_top #(
  parameter int unsigned MAX_TEXT_LEN = glb_pkg::MaxTextLen
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  glb_cfg_if.sink      cfg,
  glb_glyph_if.sink    glyph_in,
  glb_line_if.source   line_out
);

  glb_pkg::cfg_t cfg_q;
  logic qv, qr;
  glb_pkg::front_t qd;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        glb_pkg::RegWrapMode:  cfg_q.wrap_mode <= cfg.wdata[0];
        glb_pkg::RegWrapWidth: cfg_q.wrap_width <= cfg.wdata[glb_pkg::WidW-1:0];
        default: ;
      endcase
    end
  end

  glb_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(glyph_in.valid), .in_ready_o(glyph_in.ready),
    .in_data_i(glyph_in.data),
    .q_valid_o(qv), .q_ready_i(qr), .q_data_o(qd)
  );

  glb_back #(.MAX_TEXT_LEN(MAX_TEXT_LEN)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .q_valid_i(qv), .q_ready_o(qr), .q_data_i(qd),
    .out_valid_o(line_out.valid), .out_ready_i(line_out.ready),
    .out_data_o(line_out.data)
  );

  a_last_totals: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_out.valid && !line_out.data.last_line |->
      line_out.data.text_width == '0 && line_out.data.text_height == '0)
    else $error("totals on a non-final line");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_out.valid && !line_out.ready |=> line_out.valid)
    else $error("line record dropped");

  a_no_take_when_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qr |-> !(line_out.valid && !line_out.ready))
    else $error("back stage took a glyph while output stalled");

endmodule
`default_nettype wire

/* sv/glb_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// glb_front
// Accepts glyphs, classifies them and forms the metric sums; two-entry queue.
// ----------------------------------------------------------------------------
module glb_front (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  input  glb_pkg::glyph_t        in_data_i,
  output logic                   q_valid_o,
  input  wire                    q_ready_i,
  output glb_pkg::front_t        q_data_o
);

  glb_pkg::front_t ent_q [2];
  logic [1:0] cnt_q;
  logic       rd_q, wr_q;
  glb_pkg::front_t cls;
  logic push, pop;

  always_comb begin
    cls.g      = in_data_i;
    cls.m.asc  = in_data_i.glyph_ascent;
    cls.m.desc = in_data_i.glyph_descent;
    cls.m.hgt  = glb_pkg::HgtW'(in_data_i.glyph_ascent) +
                 glb_pkg::HgtW'(in_data_i.glyph_descent) +
                 glb_pkg::HgtW'(in_data_i.glyph_line_gap);
    cls.is_nl  = (in_data_i.char_class == glb_pkg::ClsNewline);
    cls.is_brk = (in_data_i.char_class == glb_pkg::ClsBreak);
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_data_o   = ent_q[rd_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = q_valid_o && q_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

/* sv/glb_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// glb_back
// Greedy break state; emits up to two line records per glyph.
// ----------------------------------------------------------------------------
module glb_back #(
  parameter int unsigned MAX_TEXT_LEN = glb_pkg::MaxTextLen
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  glb_pkg::cfg_t          cfg_i,
  input  wire                    q_valid_i,
  output logic                   q_ready_o,
  input  glb_pkg::front_t        q_data_i,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  output glb_pkg::line_t         out_data_o
);
  localparam int unsigned CW = glb_pkg::CntW;
  localparam int unsigned WW = glb_pkg::WidW;
  localparam logic [CW-1:0] Lim = (MAX_TEXT_LEN < 131071) ?
                                  CW'(MAX_TEXT_LEN) : {CW{1'b1}};

  logic [CW-1:0] gi_q, gi_d, lsg_q, lsg_d, lsb_q, lsb_d, bg_q, bg_d, bb_q, bb_d;
  logic [WW-1:0] rw_q, rw_d, bw_q, bw_d, wl_q, wl_d, hs_q, hs_d;
  logic          ne_q, ne_d;
  glb_pkg::metrics_t lm_q, lm_d, bm_q, bm_d, am_q, am_d;

  // Output slots: slot 0 shown first, slot 1 pending behind it.
  glb_pkg::line_t o0_q, o1_q;
  logic v0_q, v1_q;

  glb_pkg::line_t r0, r1;
  logic n0, n1;

  glb_pkg::front_t f;
  logic [CW-1:0] i, ni, bp, bp1;
  logic [WW:0] sum;
  logic wrapon, take;
  glb_pkg::metrics_t g, prev, zm, lmx;

  function automatic glb_pkg::line_t mk(logic [CW-1:0] fg, logic [CW-1:0] ng,
      logic [CW-1:0] fb, logic [CW-1:0] nb, logic [WW-1:0] w, glb_pkg::metrics_t m);
    glb_pkg::line_t r;
    r.line_first_glyph = fg;
    r.line_glyphs = ng;
    r.line_first_byte = fb;
    r.line_bytes = nb;
    r.line_width = w;
    r.line_ascent = m.asc;
    r.line_descent = m.desc;
    r.line_height = m.hgt;
    r.text_width = '0;
    r.text_height = '0;
    r.last_line = 1'b0;
    return r;
  endfunction

  // A new glyph may enter when no record is pending behind the shown one and the shown slot is empty or being taken.
  assign q_ready_o = !v1_q && (!v0_q || out_ready_i);
  assign take = q_valid_i && q_ready_o;
  assign out_valid_o = v0_q;
  assign out_data_o = o0_q;

  always_comb begin
    f = q_data_i;
    zm = '0;
    g = f.m;
    i = gi_q;
    ni = (i < Lim) ? i + 1'b1 : i;
    bp = {1'b0, f.g.byte_pos};
    bp1 = bp + 1'b1;
    wrapon = cfg_i.wrap_mode && (cfg_i.wrap_width != '0);
    sum = {1'b0, rw_q} + (WW+1)'(f.g.advance);
    gi_d = gi_q; lsg_d = lsg_q; lsb_d = lsb_q; bg_d = bg_q; bb_d = bb_q;
    rw_d = rw_q; bw_d = bw_q; wl_d = wl_q; hs_d = hs_q; ne_d = ne_q;
    lm_d = lm_q; bm_d = bm_q; am_d = am_q;
    r0 = '0; r1 = '0; n0 = 1'b0; n1 = 1'b0;
    prev = lm_q;
    lmx = glb_pkg::mmax(lm_q, g);
    lm_d = lmx;
    if (f.is_nl) begin
      n0 = 1'b1;
      r0 = mk(lsg_q, i - lsg_q, lsb_q, bp - lsb_q, rw_q, lmx);
      lsg_d = ni; lsb_d = bp1; rw_d = '0; bg_d = ni; bb_d = bp1; bw_d = '0;
      lm_d = zm; bm_d = zm; am_d = zm; ne_d = 1'b0;
    end else begin
      if (f.is_brk) begin
        bg_d = ni; bb_d = bp1; bw_d = glb_pkg::sat24(sum); bm_d = lmx; am_d = zm;
      end else begin
        am_d = glb_pkg::mmax(am_q, g);
      end
      if (wrapon && sum > {1'b0, cfg_i.wrap_width} && ne_q) begin
        n0 = 1'b1;
        if (bg_d > lsg_q) begin
          r0 = mk(lsg_q, bg_d - lsg_q, lsb_q, bb_d - lsb_q, bw_d, bm_d);
          lsg_d = bg_d; lsb_d = bb_d;
          rw_d = glb_pkg::sat24((sum >= {1'b0, bw_d}) ? sum - {1'b0, bw_d} : '0);
          lm_d = am_d;
          ne_d = (bg_d != ni);
        end else begin
          r0 = mk(lsg_q, i - lsg_q, lsb_q, bp - lsb_q, rw_q, prev);
          lsg_d = i; lsb_d = bp; rw_d = WW'(f.g.advance);
          lm_d = g; am_d = g; ne_d = 1'b1;
        end
        bg_d = lsg_d; bb_d = lsb_d; bw_d = '0; bm_d = zm;
      end else begin
        rw_d = glb_pkg::sat24(sum); ne_d = 1'b1;
      end
    end
    gi_d = ni;
    if (n0) begin
      wl_d = (r0.line_width > wl_d) ? r0.line_width : wl_d;
      hs_d = glb_pkg::sat24({1'b0, hs_d} + (WW+1)'(r0.line_height));
    end
    if (f.g.final_glyph) begin
      if (f.is_nl) begin
        n1 = 1'b1;
        r1 = mk(ni, '0, f.g.text_bytes, '0, '0, g);
      end else if (lsg_d != ni || !n0) begin
        n1 = 1'b1;
        r1 = mk(lsg_d, ni - lsg_d, lsb_d, f.g.text_bytes - lsb_d, rw_d, lm_d);
      end
      if (n1) begin
        wl_d = (r1.line_width > wl_d) ? r1.line_width : wl_d;
        hs_d = glb_pkg::sat24({1'b0, hs_d} + (WW+1)'(r1.line_height));
        r1.text_width = wrapon ? cfg_i.wrap_width : wl_d;
        r1.text_height = hs_d;
        r1.last_line = 1'b1;
      end else begin
        r0.text_width = wrapon ? cfg_i.wrap_width : wl_d;
        r0.text_height = hs_d;
        r0.last_line = 1'b1;
      end
      gi_d = '0; lsg_d = '0; lsb_d = '0; rw_d = '0; bg_d = '0; bb_d = '0;
      bw_d = '0; ne_d = 1'b0; lm_d = zm; bm_d = zm; am_d = zm; wl_d = '0; hs_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gi_q <= '0; lsg_q <= '0; lsb_q <= '0; bg_q <= '0; bb_q <= '0;
      rw_q <= '0; bw_q <= '0; wl_q <= '0; hs_q <= '0; ne_q <= 1'b0;
      lm_q <= '0; bm_q <= '0; am_q <= '0;
      v0_q <= 1'b0; v1_q <= 1'b0;
    end else begin
      if (take) begin
        gi_q <= gi_d; lsg_q <= lsg_d; lsb_q <= lsb_d; bg_q <= bg_d; bb_q <= bb_d;
        rw_q <= rw_d; bw_q <= bw_d; wl_q <= wl_d; hs_q <= hs_d; ne_q <= ne_d;
        lm_q <= lm_d; bm_q <= bm_d; am_q <= am_d;
        v0_q <= n0 || n1;
        v1_q <= n0 && n1;
      end else if (v0_q && out_ready_i) begin
        v0_q <= v1_q;
        v1_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      o0_q <= n0 ? r0 : r1;
      o1_q <= r1;
    end else if (v0_q && out_ready_i) begin
      o0_q <= o1_q;
    end
  end

endmodule
`default_nettype wire
